// File: rtl/follow_target_steering_macros.svh
// Assertion macros shared by the follow_target_steering RTL.
// Included by files that carry concurrent checks; depends on nothing.
`ifndef FOLLOW_TARGET_STEERING_MACROS_SVH
`define FOLLOW_TARGET_STEERING_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define FTS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must never hold outside reset.
`define FTS_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: rtl/fts_pkg.sv
// Package for follow_target_steering: widths, register codes, CORDIC types and
// the arctangent table. Depends on nothing.
`default_nettype none
package fts_pkg;

  localparam int ANGLE_STEPS = 16;
  localparam int VW = 60;
  localparam int AW = 32;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_TGAIN = 3'd1;
  localparam logic [2:0] REG_LIMIT = 3'd2;
  localparam logic [2:0] REG_GOAL  = 3'd3;
  localparam logic [2:0] REG_AGAIN = 3'd4;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_PAN_TILT = 2'd1;
  localparam logic [1:0] MODE_POSITION = 2'd2;
  localparam logic [1:0] MODE_OFF_ALT  = 2'd3;

  typedef struct packed {
    logic signed [VW-1:0] vx;
    logic signed [VW-1:0] vy;
    logic signed [AW-1:0] ang;
  } cordic_t;

  typedef struct packed {
    logic               valid;
    logic               fault;
    logic signed [31:0] y;
    cordic_t            pan;
    cordic_t            tilt;
  } cell_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [23:0] turn_gain;
    logic [16:0]        limit;
    logic [30:0]        goal;
    logic signed [23:0] approach_gain;
  } cfg_t;

  function automatic logic signed [AW-1:0] rot_angle(input logic [4:0] i);
    logic signed [AW-1:0] a;
    case (i)
      5'd0: a = 268435456;  5'd1: a = 158466703; 5'd2: a = 83729454;
      5'd3: a = 42502378;   5'd4: a = 21333666;  5'd5: a = 10677233;
      5'd6: a = 5339919;    5'd7: a = 2670123;   5'd8: a = 1335082;
      5'd9: a = 667543;     5'd10: a = 333772;   5'd11: a = 166886;
      5'd12: a = 83443;     5'd13: a = 41722;    5'd14: a = 20861;
      5'd15: a = 10430;     5'd16: a = 5215;     5'd17: a = 2608;
      5'd18: a = 1304;      5'd19: a = 652;      5'd20: a = 326;
      5'd21: a = 163;       5'd22: a = 81;       5'd23: a = 41;
      5'd24: a = 20;        5'd25: a = 10;       5'd26: a = 5;
      5'd27: a = 3;         5'd28: a = 1;        5'd29: a = 1;
      default: a = 0;
    endcase
    return a;
  endfunction

  function automatic cordic_t cordic_step(input cordic_t c, input logic [4:0] s);
    cordic_t r;
    logic signed [VW-1:0] dx;
    logic signed [VW-1:0] dy;
    dx = c.vy >>> s;
    dy = c.vx >>> s;
    if (!c.vy[VW-1]) begin
      r.vx = c.vx + dx;
      r.vy = c.vy - dy;
      r.ang = c.ang + rot_angle(s);
    end else begin
      r.vx = c.vx - dx;
      r.vy = c.vy + dy;
      r.ang = c.ang - rot_angle(s);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// File: rtl/fts_cell.sv
// One CORDIC micro-rotation cell for both the pan and the tilt vectors.
// Depends on fts_pkg.
`default_nettype none
module fts_cell
  import fts_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       en,
  input  wire logic [4:0] step,
  input  wire cell_t      d,
  output cell_t           q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.valid <= 1'b0;
    end else if (en) begin
      q.valid <= d.valid;
    end
    if (en) begin
      q.fault <= d.fault;
      q.y <= d.y;
      q.pan <= cordic_step(d.pan, step);
      q.tilt <= cordic_step(d.tilt, step);
    end
  end

endmodule
`default_nettype wire

// File: rtl/fts_post.sv
// Gain products, rounding, saturation and mode selection, then the output register.
// Depends on fts_pkg and the assertion macros.
`default_nettype none
`include "follow_target_steering_macros.svh"
module fts_post
  import fts_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire cfg_t         cfg,
  input  wire cell_t        d,
  output logic              ready,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic signed [31:0] angular_rate,
  output logic signed [31:0] forward_speed,
  output logic signed [15:0] tilt_degrees,
  output logic              velocity_valid,
  output logic              tilt_valid,
  output logic              turning_only,
  output logic              range_fault
);

  logic                p_valid;
  logic                p_fault;
  logic                p_turn;
  logic signed [41:0]  p_ang;
  logic signed [56:0]  p_fwd;
  logic signed [48:0]  p_tilt;
  logic                o_ready;
  logic                p_ready;
  logic signed [AW-1:0] pan_sum;
  logic signed [17:0]  pan;
  logic [17:0]         pan_mag;
  logic signed [32:0]  range_err;
  logic signed [41:0]  ang_r;
  logic signed [56:0]  fwd_r;
  logic signed [48:0]  tilt_r;
  logic signed [25:0]  ang_s;
  logic signed [40:0]  fwd_s;
  logic signed [18:0]  tilt_s;
  logic                act;
  logic                pos;

  assign o_ready = !out_valid || out_ready;
  assign p_ready = !p_valid || o_ready;
  assign ready = p_ready;

  assign pan_sum = d.pan.ang + AW'(8192);
  assign pan = 18'(pan_sum >>> 14);
  assign pan_mag = pan[17] ? 18'(-pan) : pan;
  assign range_err = 33'(d.y) - 33'($signed({1'b0, cfg.goal}));

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (p_ready) begin
      p_valid <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (p_ready) begin
      p_fault <= d.fault;
      p_turn <= pan_mag > {1'b0, cfg.limit};
      p_ang <= 42'(cfg.turn_gain) * 42'(pan);
      p_fwd <= 57'(cfg.approach_gain) * 57'(range_err);
      p_tilt <= 49'(d.tilt.ang) * 49'sd46080;
    end
  end

  assign ang_r = p_ang + 42'sd32768;
  assign fwd_r = p_fwd + 57'sd32768;
  assign tilt_r = p_tilt + 49'sd536870912;
  assign ang_s = 26'(ang_r >>> 16);
  assign fwd_s = 41'(fwd_r >>> 16);
  assign tilt_s = 19'(tilt_r >>> 30);
  assign act = !p_fault && (cfg.mode == MODE_PAN_TILT || cfg.mode == MODE_POSITION);
  assign pos = act && cfg.mode == MODE_POSITION && !p_turn;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (o_ready) begin
      out_valid <= p_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (o_ready) begin
      range_fault <= p_fault;
      velocity_valid <= act;
      tilt_valid <= act;
      turning_only <= act && p_turn;
      angular_rate <= act ? 32'(ang_s) : '0;
      if (!pos) begin
        forward_speed <= '0;
      end else if (fwd_s > 41'sd2147483647) begin
        forward_speed <= 32'sh7FFFFFFF;
      end else if (fwd_s < -41'sd2147483648) begin
        forward_speed <= 32'sh80000000;
      end else begin
        forward_speed <= 32'(fwd_s);
      end
      if (!act) begin
        tilt_degrees <= '0;
      end else if (tilt_s > 19'sd7680) begin
        tilt_degrees <= 16'sd7680;
      end else begin
        tilt_degrees <= 16'(tilt_s);
      end
    end
  end

  `FTS_ASSERT_IMPL(a_fault_silent, clk, rst, out_valid && range_fault,
    !velocity_valid && !tilt_valid, "fault item carries a command")
  `FTS_ASSERT_IMPL(a_tilt_cap, clk, rst, out_valid,
    tilt_degrees <= 16'sd7680, "tilt above cap")
  `FTS_ASSERT_IMPL(a_no_cmd_zero, clk, rst, out_valid && !velocity_valid,
    angular_rate == 0 && forward_speed == 0, "command fields set without valid")

endmodule
`default_nettype wire

// File: rtl/follow_target_steering.sv
// Follow-target steering: tdata in = target_x, target_y, target_z (Q16.16).
// Result tdata = angular_rate, forward_speed, tilt_degrees; tuser holds
// velocity_valid, tilt_valid, turning_only, range_fault from bit 0 up.
// A transfer happens when tvalid and tready are both high.
// Each target passes a preparation step into a chain of 16 CORDIC cells, one
// micro-rotation per cell for pan and tilt together, then a product stage and
// an output register.
// One item is accepted every cycle until a receiver stall has filled every stage.
// Configuration is written through cfg_we, cfg_index and cfg_data and takes
// effect on items still in flight, so write only while the block is idle.
// Reset empties the pipeline and loads the register defaults.
// When the receiver stalls, occupied stages hold and empty stages still fill,
// so input tready drops only once every stage holds an item.
// Depends on fts_pkg, fts_cell and fts_post.
`default_nettype none
module follow_target_steering
  import fts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // target_x, target_y, target_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [79:0]      m_axis_tdata,   // angular_rate, forward_speed, tilt_degrees
  output logic [3:0]       m_axis_tuser,   // velocity_valid, tilt_valid, turning_only,
                                           // range_fault
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [30:0] cfg_data
);

  cfg_t  cfg;
  cell_t chain [ANGLE_STEPS+1];
  logic  rdy [ANGLE_STEPS+1];
  logic signed [31:0] tx, ty, tz;
  logic signed [VW-1:0] ys, xs, zs;
  logic signed [31:0] ang_rate, fwd, tilt_unused_hi;
  logic signed [15:0] tilt;
  logic vel_ok, tilt_ok, turn_only, fault;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode <= MODE_POSITION;
      cfg.turn_gain <= 24'sd65536;
      cfg.limit <= 17'd10923;
      cfg.goal <= 31'd98304;
      cfg.approach_gain <= 24'sd19661;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MODE:  cfg.mode <= cfg_data[1:0];
        REG_TGAIN: cfg.turn_gain <= cfg_data[23:0];
        REG_LIMIT: cfg.limit <= cfg_data[16:0];
        REG_GOAL:  cfg.goal <= cfg_data;
        REG_AGAIN: cfg.approach_gain <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  assign tx = s_axis_tdata[31:0];
  assign ty = s_axis_tdata[63:32];
  assign tz = s_axis_tdata[95:64];
  assign ys = VW'(ty);
  assign xs = VW'(tx);
  assign zs = VW'(tz);

  always_comb begin
    chain[0].valid = s_axis_tvalid;
    chain[0].fault = ty == 32'sd0;
    chain[0].y = ty;
    chain[0].pan.vx = (ty[31] ? -ys : ys) <<< 24;
    chain[0].pan.vy = (ty[31] ? -xs : xs) <<< 24;
    chain[0].pan.ang = '0;
    chain[0].tilt.vx = (ty[31] ? -ys : ys) <<< 24;
    chain[0].tilt.vy = (ty[31] ? -zs : zs) <<< 24;
    chain[0].tilt.ang = '0;
  end

  for (genvar i = 0; i < ANGLE_STEPS; i++) begin : g_cell
    assign rdy[i] = !chain[i+1].valid || rdy[i+1];
    fts_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .en   (rdy[i]),
      .step (5'(i)),
      .d    (chain[i]),
      .q    (chain[i+1])
    );
  end

  assign s_axis_tready = rdy[0];
  assign tilt_unused_hi = '0;

  fts_post u_post (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .d              (chain[ANGLE_STEPS]),
    .ready          (rdy[ANGLE_STEPS]),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .angular_rate   (ang_rate),
    .forward_speed  (fwd),
    .tilt_degrees   (tilt),
    .velocity_valid (vel_ok),
    .tilt_valid     (tilt_ok),
    .turning_only   (turn_only),
    .range_fault    (fault)
  );

  assign m_axis_tdata = {tilt, fwd, ang_rate | tilt_unused_hi};
  assign m_axis_tuser = {fault, turn_only, tilt_ok, vel_ok};

endmodule
`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for follow_target_steering: random and directed target
// transfers checked against a behavioral steering and tilt predictor.
// Depends on fts_pkg and the follow_target_steering RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_top
  import fts_pkg::*;
();

  localparam int LATENCY = 18;
  localparam longint LIMIT = 3000000;

  typedef struct {
    logic signed [31:0] ang;
    logic signed [31:0] fwd;
    logic signed [15:0] tilt;
    logic [3:0]         flags;
  } command_t;

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 typed;
    logic [3:0]         flags;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [95:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [79:0] m_axis_tdata;
  logic [3:0] m_axis_tuser;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  logic [1:0] cur_mode;
  logic signed [23:0] cur_tgain;
  logic [16:0] cur_limit;
  logic [30:0] cur_goal;
  logic signed [23:0] cur_again;

  command_t pending_cmds[$];
  int errors = 0;
  longint cycles = 0;
  bit hold_sink = 1'b0;

  follow_target_steering i_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint arctan_pi(longint num, longint den);
    longint vx, vy, dx, dy, a;
    longint angles[32] = '{268435456, 158466703, 83729454, 42502378, 21333666, 10677233,
      5339919, 2670123, 1335082, 667543, 333772, 166886, 83443, 41722, 20861, 10430,
      5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0, 0};
    vx = (den < 0 ? -den : den) * 64'sd16777216;
    vy = (den < 0 ? -num : num) * 64'sd16777216;
    a = 0;
    for (int i = 0; i < ANGLE_STEPS && i < 32; i++) begin
      dx = floor_shift(vy, i);
      dy = floor_shift(vx, i);
      if (vy >= 0) begin
        vx += dx; vy -= dy; a += angles[i];
      end else begin
        vx -= dx; vy += dy; a -= angles[i];
      end
    end
    return a;
  endfunction

  function automatic command_t steer(longint x, longint y, longint z);
    command_t c;
    longint pan, mag, t;
    c.ang = '0; c.fwd = '0; c.tilt = '0; c.flags = '0;
    if (y == 0) begin
      c.flags[3] = 1'b1;
    end else if (cur_mode == MODE_PAN_TILT || cur_mode == MODE_POSITION) begin
      pan = floor_shift(arctan_pi(x, y) + 8192, 14);
      mag = pan < 0 ? -pan : pan;
      c.ang = 32'(clamp32(floor_shift(longint'(cur_tgain) * pan + 32768, 16)));
      c.flags[0] = 1'b1;
      c.flags[2] = mag > longint'(cur_limit);
      if (cur_mode == MODE_POSITION && !c.flags[2])
        c.fwd = 32'(clamp32(floor_shift(longint'(cur_again) * (y - longint'(cur_goal))
                                        + 32768, 16)));
      t = floor_shift(arctan_pi(z, y) * 46080 + 64'sd536870912, 30);
      if (t > 7680) t = 7680;
      c.tilt = 16'(t);
      c.flags[1] = 1'b1;
    end
    return c;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [30:0] val);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode = val[1:0];
      REG_TGAIN: cur_tgain = val[23:0];
      REG_LIMIT: cur_limit = val[16:0];
      REG_GOAL:  cur_goal = val;
      REG_AGAIN: cur_again = val[23:0];
      default: ;
    endcase
  endtask

  task automatic stop_input;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain;
    stop_input();
    while (pending_cmds.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic send_item(command_t c, logic signed [31:0] x, y, z, int gap);
    if (gap > 0) begin
      stop_input();
      repeat (gap - 1) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {z, y, x};
    do @(posedge clk); while (!s_axis_tready);
    pending_cmds.push_back(c);
  endtask

  task automatic send_target(logic signed [31:0] x, y, z, int gap);
    command_t c;
    c = steer(longint'(x), longint'(y), longint'(z));
    send_item(c, x, y, z, gap);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      3: return $signed($urandom_range(0, 8)) - 4;
      default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  always @(posedge clk) begin
    command_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (pending_cmds.size() == 0) begin
        $display("%0t unexpected transfer %h %h", $time, m_axis_tdata, m_axis_tuser);
        errors++;
      end else begin
        e = pending_cmds.pop_front();
        if (m_axis_tdata[31:0] !== e.ang) begin
          $display("%0t angular_rate exp %0d got %0d", $time, e.ang,
                   $signed(m_axis_tdata[31:0]));
          errors++;
        end
        if (m_axis_tdata[63:32] !== e.fwd) begin
          $display("%0t forward_speed exp %0d got %0d", $time, e.fwd,
                   $signed(m_axis_tdata[63:32]));
          errors++;
        end
        if (m_axis_tdata[79:64] !== e.tilt) begin
          $display("%0t tilt_degrees exp %0d got %0d", $time, e.tilt,
                   $signed(m_axis_tdata[79:64]));
          errors++;
        end
        if (m_axis_tuser !== e.flags) begin
          $display("%0t flags exp %b got %b", $time, e.flags, m_axis_tuser);
          errors++;
        end
      end
    end
  end

  // The receiver stalls at random; a hold request freezes it for a long stretch.
  initial begin
    int w;
    @(negedge rst);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 1'b0;
        repeat (200) @(posedge clk);
        hold_sink = 1'b0;
      end
      w = $urandom_range(0, 19);
      if ($urandom_range(0, 3) == 0) w = 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid && !hold_sink);
    end
  end

  initial begin
    row_t rows[$];
    row_t r;
    command_t c;
    int gap;
    cur_mode = MODE_POSITION; cur_tgain = 65536; cur_limit = 10923; cur_goal = 98304;
    cur_again = 19661;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    rows.push_back('{32'sd0, 32'sd0, 32'sd0, 1'b1, 4'b1000});
    rows.push_back('{32'sh7fffffff, 32'sd0, 32'sh80000000, 1'b1, 4'b1000});
    rows.push_back('{32'sd0, 32'sd65536, 32'sd0, 1'b0, 4'b0});
    rows.push_back('{32'sh7fffffff, 32'sd1, 32'sh7fffffff, 1'b0, 4'b0});
    rows.push_back('{32'sh80000000, 32'sd1, 32'sh80000000, 1'b0, 4'b0});
    rows.push_back('{32'sd65536, 32'sh80000000, 32'sd65536, 1'b0, 4'b0});
    rows.push_back('{32'sd1000, 32'sh7fffffff, 32'sd0, 1'b0, 4'b0});
    rows.push_back('{32'sd65536, 32'sd65536, -32'sd65536, 1'b0, 4'b0});
    rows.push_back('{-32'sd300, 32'sd400000, 32'sd30000, 1'b0, 4'b0});
    rows.push_back('{32'sd3, -32'sd5, -32'sd7, 1'b0, 4'b0});
    foreach (rows[i]) begin
      r = rows[i];
      if (r.typed) begin
        c = '{32'sd0, 32'sd0, 16'sd0, r.flags};
        send_item(c, r.x, r.y, r.z, $urandom_range(0, 3));
      end else begin
        send_target(r.x, r.y, r.z, $urandom_range(0, 3));
      end
    end
    drain();

    for (int phase = 0; phase < 9; phase++) begin
      write_reg(REG_MODE, 31'(phase % 4 == 0 ? MODE_PAN_TILT :
                              (phase == 3 ? MODE_OFF :
                               (phase == 7 ? MODE_OFF_ALT : MODE_POSITION))));
      case (phase % 3)
        0: write_reg(REG_TGAIN, 31'h7fffff);
        1: write_reg(REG_TGAIN, 31'h800000);
        default: write_reg(REG_TGAIN, 31'($urandom));
      endcase
      write_reg(REG_LIMIT, 31'(phase == 1 ? 0 :
                               (phase == 2 ? 65536 : $urandom_range(0, 65536))));
      write_reg(REG_GOAL, 31'(phase == 4 ? 32'h7fffffff : (phase == 5 ? 0 : $urandom)));
      write_reg(REG_AGAIN, 31'(phase == 6 ? 32'h800000 :
                               (phase == 8 ? 32'h7fffff : $urandom)));
      for (int n = 0; n < 200; n++) begin
        gap = (phase == 2 && n > 20 && n < 80) ? 0 : $urandom_range(0, 19);
        if ($urandom_range(0, 2) == 0) gap = 0;
        if (phase == 2 && n == 20) hold_sink = 1'b1;
        if (n == 100) begin
          stop_input();
          while (pending_cmds.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 29) == 0)
          send_target(rand_coord(), 32'sd0, rand_coord(), gap);
        else
          send_target(rand_coord(), rand_coord(), rand_coord(), gap);
      end
      drain();
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire
